// ----- src/b64e_pkg.sv -----
package b64e_pkg;

  // Characters a single input byte can give rise to, at most.
  localparam int unsigned MaxChars = 4;
  localparam int unsigned CntW     = $clog2(MaxChars);

  // Entries of the queue between the front and the back part.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;
  localparam logic [CfgIdxW-1:0] CfgUrlAlphabet = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOmitPadding = 1'b1;

  localparam logic [6:0] PadChar = 7'h3D;

  // Position of the next byte within its three-byte group.
  typedef enum logic [1:0] {
    PosFirst  = 2'd0,
    PosSecond = 2'd1,
    PosThird  = 2'd2
  } grp_pos_e;

  typedef struct packed {
    logic url_alphabet;
    logic omit_padding;
  } cfg_t;

  // One queued unit of work: the characters of one input byte.
  typedef struct packed {
    logic [MaxChars-1:0][6:0] chars;    // chars[0] goes out first
    logic [CntW-1:0]          last_idx; // index of the final character
    logic                     msg_end;  // this byte closed the message
  } job_t;

  // Maps a six-bit value onto its Base64 character.
  function automatic logic [6:0] b64e_sym(input logic [5:0] v, input logic url);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = url ? 7'h2D : 7'h2B;
    end else begin
      c = url ? 7'h5F : 7'h2F;
    end
    return c;
  endfunction

endpackage

// ----- src/b64e_front.sv -----
module b64e_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b64e_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  input  logic           q_full_i,
  output logic           in_ready_o,
  output logic           push_o,
  output b64e_pkg::job_t job_o
);
  import b64e_pkg::*;

  grp_pos_e   pos_q, pos_d;
  logic [3:0] left_q, left_d;
  logic       pad;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign pad        = !cfg_i.omit_padding;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosFirst;
      left_q <= 4'd0;
    end else begin
      pos_q  <= pos_d;
      left_q <= left_d;
    end
  end

  always_comb begin
    job_o         = '0;
    job_o.msg_end = in_last_i;
    pos_d         = pos_q;
    left_d        = left_q;
    case (pos_q)
      PosSecond: begin
        job_o.chars[0] = b64e_sym({left_q[1:0], in_byte_i[7:4]}, cfg_i.url_alphabet);
        if (in_last_i) begin
          job_o.chars[1] = b64e_sym({in_byte_i[3:0], 2'b00}, cfg_i.url_alphabet);
          job_o.chars[2] = PadChar;
          job_o.last_idx = pad ? CntW'(2) : CntW'(1);
        end
        pos_d  = PosThird;
        left_d = in_byte_i[3:0];
      end
      PosThird: begin
        job_o.chars[0] = b64e_sym({left_q, in_byte_i[7:6]}, cfg_i.url_alphabet);
        job_o.chars[1] = b64e_sym(in_byte_i[5:0], cfg_i.url_alphabet);
        job_o.last_idx = CntW'(1);
        pos_d  = PosFirst;
        left_d = 4'd0;
      end
      default: begin
        job_o.chars[0] = b64e_sym(in_byte_i[7:2], cfg_i.url_alphabet);
        if (in_last_i) begin
          job_o.chars[1] = b64e_sym({in_byte_i[1:0], 4'b0000}, cfg_i.url_alphabet);
          job_o.chars[2] = PadChar;
          job_o.chars[3] = PadChar;
          job_o.last_idx = pad ? CntW'(3) : CntW'(1);
        end
        pos_d  = PosSecond;
        left_d = {2'b00, in_byte_i[1:0]};
      end
    endcase
    if (in_last_i) begin
      pos_d  = PosFirst;
      left_d = 4'd0;
    end
    if (!push_o) begin
      pos_d  = pos_q;
      left_d = left_q;
    end
  end

endmodule

// ----- src/b64e_queue.sv -----
module b64e_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output b64e_pkg::job_t head_o
);
  import b64e_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ----- src/b64e_back.sv -----
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  b64e_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [6:0]     out_char_o,
  output logic           out_run_last_o,
  output logic           out_msg_end_o
);
  import b64e_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [6:0]      char_q;
  logic            run_last_q, msg_end_q;
  logic            load, at_last;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_last ? '0 : idx_q + CntW'(1);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q     <= head_i.chars[idx_q];
      run_last_q <= at_last;
      msg_end_q  <= at_last && head_i.msg_end;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_char_o     = char_q;
  assign out_run_last_o = run_last_q;
  assign out_msg_end_o  = msg_end_q;

endmodule

// ----- src/base64_stream_encoder_top.sv -----
// Streaming Base64 encoder (RFC 4648, standard or URL-safe alphabet). Message
// bytes arrive on the slave stream, one byte per transfer, with tlast set on
// the final byte of a message; Base64 characters leave on the master stream,
// one character per transfer. A full three-byte group gives one, one and two
// characters for its bytes; a byte that ends a message early also gives the
// character holding the leftover bits and, unless padding is switched off,
// the '=' characters up to four. The output tlast marks the final character
// caused by each input byte and tuser marks the final character of the
// message. The input is accepted in every cycle while the two-entry queue
// between the byte front end and the character back end has room, so bytes
// enter back to back; the back end sends one character per cycle from its
// output register unless stalled; a byte yields one or two characters within
// a group (four characters per three bytes sustained) and up to four at the
// end of a message. The first character of a byte appears once loaded into
// the output register. Configuration is written through the plain
// write port (index 0: URL-safe alphabet, index 1: omit padding) and should
// only be changed while the encoder is idle. There is no clearing pass.
module base64_stream_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,

  // Configuration write port.
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_data_i,

  // Byte input stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // is_last

  // Character output stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // [0] message_end
);
  import b64e_pkg::*;

  cfg_t       cfg_q;
  logic       q_full, q_valid, push, pop;
  job_t       job, head;
  logic [6:0] out_char;

  // Configuration registers; a write simply lands in the addressed register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgUrlAlphabet: cfg_q.url_alphabet <= cfg_data_i;
        CfgOmitPadding: cfg_q.omit_padding <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end tracks the group position and leftover bits and turns each
  // byte into a job holding all of its characters.
  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .job_o      (job)
  );

  // The queue lets the front end keep taking bytes while characters of
  // earlier bytes are still being sent.
  b64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // The back end walks the head job's characters, one per cycle unless stalled,
  // and releases the job once its final character is in the output register.
  b64e_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_char_o     (out_char),
    .out_run_last_o (m_axis_tlast),
    .out_msg_end_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

// ----- src/b64e_checker.sv -----
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // The end of a message is always the final character of its byte.
  a_msg_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("message end without run end");

  // Characters are seven-bit ASCII.
  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[7])
    else $error("character outside seven-bit ASCII");

  // Input back-pressure only arises while a character is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output");

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output changed");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
